/* sv/chess_attack_set_generator_macros.svh */
// Assertion macros shared by the attack generator checker
`ifndef CHESS_ATTACK_SET_GENERATOR_MACROS_SVH
`define CHESS_ATTACK_SET_GENERATOR_MACROS_SVH
// Assert that an implication holds on every clock edge outside reset
`define CASG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that an implication holds in the cycle after the antecedent
`define CASG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/casg_pkg.sv */
// Types and constants for the attack set generator
package casg_pkg;
    localparam int unsigned NumSteps = 7;
    typedef logic [63:0] t_board;
    typedef logic [2:0]  t_func;
    typedef logic [3:0]  t_ray;

    localparam t_func FUNC_BISHOP = 3'd0;
    localparam t_func FUNC_ROOK   = 3'd1;
    localparam t_func FUNC_QUEEN  = 3'd2;
    localparam t_func FUNC_KING   = 3'd3;
    localparam t_func FUNC_KNIGHT = 3'd4;
    localparam t_func FUNC_PAWN   = 3'd5;

    localparam t_ray RAY_ALL = 4'd0;
    localparam t_ray RAY_N   = 4'd1;
    localparam t_ray RAY_S   = 4'd2;
    localparam t_ray RAY_E   = 4'd3;
    localparam t_ray RAY_W   = 4'd4;
    localparam t_ray RAY_NE  = 4'd5;
    localparam t_ray RAY_NW  = 4'd6;
    localparam t_ray RAY_SE  = 4'd7;
    localparam t_ray RAY_SW  = 4'd8;

    // frontier lane index per direction
    localparam int unsigned DIR_N  = 0;
    localparam int unsigned DIR_S  = 1;
    localparam int unsigned DIR_E  = 2;
    localparam int unsigned DIR_W  = 3;
    localparam int unsigned DIR_NE = 4;
    localparam int unsigned DIR_NW = 5;
    localparam int unsigned DIR_SE = 6;
    localparam int unsigned DIR_SW = 7;

    localparam t_board FILE_A = 64'h0101010101010101;
    localparam t_board FILE_B = 64'h0202020202020202;
    localparam t_board FILE_G = 64'h4040404040404040;
    localparam t_board FILE_H = 64'h8080808080808080;

    typedef struct packed {
        logic   vld;
        t_board occ;
    } t_cell_ctl;

    function automatic t_board shift_dir(input t_board b, input int unsigned d);
        t_board r;
        case (d)
            DIR_N:   r = b << 8;
            DIR_S:   r = b >> 8;
            DIR_E:   r = (b << 1) & ~FILE_A;
            DIR_W:   r = (b >> 1) & ~FILE_H;
            DIR_NE:  r = (b << 9) & ~FILE_A;
            DIR_NW:  r = (b << 7) & ~FILE_H;
            DIR_SE:  r = (b >> 7) & ~FILE_A;
            DIR_SW:  r = (b >> 9) & ~FILE_H;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_board knight_set(input t_board k);
        t_board a;
        a = '0;
        if ((k & FILE_H) == '0) begin
            a = a | (k << 17) | (k >> 15);
            if ((k & FILE_G) == '0) a = a | (k << 10) | (k >> 6);
        end
        if ((k & FILE_A) == '0) begin
            a = a | (k >> 17) | (k << 15);
            if ((k & FILE_B) == '0) a = a | (k >> 10) | (k << 6);
        end
        return a;
    endfunction
endpackage

/* sv/casg_if.sv */
// Valid/ready channel interfaces for query and result
interface casg_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [5:0] square;
    logic [63:0] occupancy;
    logic       side;
    logic [3:0] ray_select;
    modport source (output valid, func, square, occupancy, side, ray_select, input ready);
    modport sink (input valid, func, square, occupancy, side, ray_select, output ready);
endinterface

interface casg_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] attack_set;
    modport source (output valid, attack_set, input ready);
    modport sink (input valid, attack_set, output ready);
endinterface

/* sv/casg_ray_cell.sv */
// One ray step cell: advance all eight frontiers by one square
module casg_ray_cell
    import casg_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_board    i_front [8],
    input  t_board    i_acc [8],
    output t_board    o_front [8],
    output t_board    o_acc [8],
    output t_board    o_occ
);
    t_board r_front [8];
    t_board r_acc [8];
    t_board r_occ;

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_occ <= i_ctl.occ;
            for (int d = 0; d < 8; d++) begin
                r_acc[d]   <= i_acc[d] | shift_dir(i_front[d], d);
                r_front[d] <= shift_dir(i_front[d], d) & ~i_ctl.occ;
            end
        end
    end

    assign o_front = r_front;
    assign o_acc   = r_acc;
    assign o_occ   = r_occ;
endmodule

/* sv/chess_attack_set_generator.sv */
// Top level: bitboard attack generator built as a chain of ray step cells
// A transferred query is registered, walks through the 7 ray cells and is then
// combined into the result register. One query is in the chain at a time, and a
// finished query waits in the last step while an earlier result still awaits its
// transfer; a new query is taken only once the last one has left the chain.
// Reset: synchronous active-low i_rst_n clears the busy and valid flags;
// payload registers are not reset.
module chess_attack_set_generator
    import casg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    casg_in_if.sink    i_in,
    casg_out_if.source o_out
);
    // query held for the whole walk
    logic       r_busy;
    logic [3:0] r_cnt;
    t_func      r_func;
    t_ray       r_sel;
    logic       r_side;
    t_board     r_from;
    t_board     r_occ;
    logic       r_ovld;
    t_board     r_res;

    // frontier/accumulator seeds into cell 0
    t_board     w_front [NumSteps+1][8];
    t_board     w_acc [NumSteps+1][8];
    t_board     w_occ [NumSteps+1];

    // accept whenever the chain is free; a waiting result only holds the last step
    assign i_in.ready = !r_busy;
    wire w_take = i_in.valid && i_in.ready;

    // final step done and the result register free or emptying this cycle
    logic w_done;
    assign w_done = r_busy && (r_cnt == 4'(NumSteps)) && (!r_ovld || o_out.ready);

    assign w_front[0] = '{default: r_from};
    assign w_acc[0]   = '{default: '0};
    assign w_occ[0]   = r_occ;

    // cells advance in lock step while busy; the chain just flows each cycle
    for (genvar g = 0; g < NumSteps; g++) begin : g_cell
        t_cell_ctl ctl;
        assign ctl = {r_busy, w_occ[g]};
        casg_ray_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_front(w_front[g]),
            .i_acc  (w_acc[g]),
            .o_front(w_front[g+1]),
            .o_acc  (w_acc[g+1]),
            .o_occ  (w_occ[g+1])
        );
    end

    // combine the rays for the piece and ray selection
    t_board n_res;
    t_board w_rook;
    t_board w_bish;
    always_comb begin
        w_rook = '0;
        w_bish = '0;
        for (int d = 0; d < 4; d++) begin
            if (r_sel == RAY_ALL || r_sel == t_ray'(d + 1))
                w_rook = w_rook | w_acc[NumSteps][d];
        end
        for (int d = 4; d < 8; d++) begin
            if (r_sel == RAY_ALL || r_sel == t_ray'(d + 1))
                w_bish = w_bish | w_acc[NumSteps][d];
        end
        n_res = '0;
        case (r_func)
            FUNC_BISHOP: n_res = w_bish;
            FUNC_ROOK:   n_res = w_rook;
            FUNC_QUEEN:  n_res = w_bish | w_rook;
            FUNC_KING: begin
                for (int unsigned d = 0; d < 8; d++) n_res = n_res | shift_dir(r_from, d);
            end
            FUNC_KNIGHT: n_res = knight_set(r_from);
            FUNC_PAWN:   n_res = r_side ? (shift_dir(r_from, DIR_SW) | shift_dir(r_from, DIR_SE))
                                        : (shift_dir(r_from, DIR_NW) | shift_dir(r_from, DIR_NE));
            default:     n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && r_cnt != 4'(NumSteps)) begin
                // advance until the last cell has the final step, then hold
                r_cnt <= r_cnt + 4'd1;
            end
            if (w_done) begin
                r_ovld <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_func <= i_in.func;
            r_sel  <= i_in.ray_select;
            r_side <= i_in.side;
            r_from <= t_board'(64'd1) << i_in.square;
            r_occ  <= i_in.occupancy;
        end
        if (w_done) r_res <= n_res;
    end

    assign o_out.valid      = r_ovld;
    assign o_out.attack_set = r_res;
endmodule

/* sv/casg_checker.sv */
// Port checker for the attack generator, bound to the top level
`include "chess_attack_set_generator_macros.svh"
module casg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_data
);
    `CASG_ASSERT_IMP(a_out_known, i_clk, i_rst_n, out_valid, !$isunknown(out_data))
    `CASG_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `CASG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind chess_attack_set_generator casg_checker u_casg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (i_in.valid),
    .in_ready (i_in.ready),
    .out_valid(o_out.valid),
    .out_ready(o_out.ready),
    .out_data (o_out.attack_set)
);
